[design/wrs_pkg.sv]
// Shared types, constants and helper functions for the watermark refill scheduler.
// Has no dependencies; every other design file imports it.
`default_nettype none

package wrs_pkg;

  // Field widths.
  localparam int SLOT_W  = 7;
  localparam int GAP_W   = 8;
  localparam int FRAME_W = 8;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 32;
  localparam int REQ_W   = SLOT_W + 1;
  localparam int PROD_W  = CNT_W + SLOT_W;
  localparam int MUL_STEPS = SLOT_W;
  localparam int STEP_W  = $clog2(MUL_STEPS);

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = 3;

  // Fixed limits checked by a start request.
  localparam int MAX_POOL   = 64;
  localparam int ISO_FRAMES = 8;

  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PERIOD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POOL    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAP     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CAPTURE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FRAMES  = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0]  target_lead;
    logic [SLOT_W-1:0]  low_watermark;
    logic [SLOT_W-1:0]  high_watermark;
    logic [SLOT_W-1:0]  max_per_submit;
    logic [SLOT_W-1:0]  pool_size;
    logic [GAP_W-1:0]   completion_gap;
    logic               capture_every_period;
    logic [FRAME_W-1:0] frames_per_packet;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_lead:          7'd4,
    low_watermark:        7'd2,
    high_watermark:       7'd8,
    max_per_submit:       7'd4,
    pool_size:            7'd16,
    completion_gap:       8'd1,
    capture_every_period: 1'b1,
    frames_per_packet:    8'd8
  };

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] lead_slots;
    logic [SLOT_W-1:0] submitted_slots;
    logic              cadence_ok;
    logic              capture_ok;
    logic              lead_safe;
    logic              batching_ok;
    logic              pool_ok;
    logic              callback_ok;
    logic              all_safe;
  } result_t;

  // Saturating counter increment.
  function automatic cnt_t sat_inc(cnt_t c);
    return (c == CNT_MAX) ? c : c + cnt_t'(1);
  endfunction

  // Saturating add of a slot count.
  function automatic cnt_t sat_add(cnt_t c, logic [REQ_W-1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W+1)'(n);
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/wrs_regs.sv]
// Configuration register file with an APB-style write and read port.
// Depends on wrs_pkg for the register layout and reset values.
`default_nettype none

module wrs_regs import wrs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TARGET:  cfg_d.target_lead          = pwdata[SLOT_W-1:0];
        REG_LOW:     cfg_d.low_watermark        = pwdata[SLOT_W-1:0];
        REG_HIGH:    cfg_d.high_watermark       = pwdata[SLOT_W-1:0];
        REG_MAX:     cfg_d.max_per_submit       = pwdata[SLOT_W-1:0];
        REG_POOL:    cfg_d.pool_size            = pwdata[SLOT_W-1:0];
        REG_GAP:     cfg_d.completion_gap       = pwdata[GAP_W-1:0];
        REG_CAPTURE: cfg_d.capture_every_period = pwdata[0];
        REG_FRAMES:  cfg_d.frames_per_packet    = pwdata[FRAME_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET:  prdata = APB_DW'(cfg_q.target_lead);
      REG_LOW:     prdata = APB_DW'(cfg_q.low_watermark);
      REG_HIGH:    prdata = APB_DW'(cfg_q.high_watermark);
      REG_MAX:     prdata = APB_DW'(cfg_q.max_per_submit);
      REG_POOL:    prdata = APB_DW'(cfg_q.pool_size);
      REG_GAP:     prdata = APB_DW'(cfg_q.completion_gap);
      REG_CAPTURE: prdata = APB_DW'(cfg_q.capture_every_period);
      REG_FRAMES:  prdata = APB_DW'(cfg_q.frames_per_packet);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[design/wrs_mul.sv]
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// Depends on wrs_pkg for operand widths and the step count.
`default_nettype none

module wrs_mul import wrs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire cnt_t              mcand_i,
  input  wire logic [SLOT_W-1:0] mplier_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      prod_o
);

  logic [PROD_W-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [SLOT_W-1:0] mplier_q, mplier_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d, done_q, done_d;

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    step_d   = step_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = PROD_W'(mcand_i);
      mplier_d = mplier_i;
      step_d   = STEP_W'(MUL_STEPS - 1);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

endmodule

`default_nettype wire

[design/wrs_core.sv]
// Request sequencer, lead and counter state, and safety flag evaluation.
// Depends on wrs_pkg and instantiates wrs_mul for the batching check.
`default_nettype none

module wrs_core import wrs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic              force_capture_gap_i,
  input  wire logic              force_batch_overflow_i,
  input  wire logic              suppress_submit_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output result_t                res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // Latched request.
  logic [MODE_W-1:0] mode_q;
  logic              fgap_q, fover_q, supp_q;

  // Scheduler state.
  cfg_t              act_q, act_d;
  logic              running_q, running_d;
  logic [SLOT_W-1:0] lead_q, lead_d, min_q, min_d, max_q, max_d;
  logic [GAP_W-1:0]  phase_q, phase_d;
  cnt_t period_q, period_d, gaps_q, gaps_d, cadence_q, cadence_d;
  cnt_t under_q, under_d, povf_q, povf_d, bovf_q, bovf_d;
  cnt_t total_q, total_d, calls_q, calls_d, cbsub_q, cbsub_d;
  logic              acc_q, acc_d;
  logic [SLOT_W-1:0] sub_q, sub_d;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic              mul_done;
  logic [PROD_W-1:0] prod;

  // Step datapath.
  logic              start_ok, do_start, do_period, cap_hit, period_sat;
  logic [GAP_W-1:0]  phase_inc, phase_new;
  logic [SLOT_W-1:0] lead_mid, want, want_min, s_max, s_pool, s_lead, room;
  logic [REQ_W-1:0]  req, s1, sum, grant;
  logic              b_ovf, p_ovf, go;
  cnt_t              base_povf, base_bovf, base_total, base_calls, base_cbsub;
  logic              f_cad, f_cap, f_lead, f_bat, f_pool, f_cb;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign start_ok = (cfg_i.frames_per_packet == FRAME_W'(ISO_FRAMES)) &&
                    (cfg_i.target_lead != '0) && (cfg_i.low_watermark != '0) &&
                    (cfg_i.high_watermark >= cfg_i.target_lead) &&
                    (cfg_i.low_watermark < cfg_i.high_watermark) &&
                    (cfg_i.max_per_submit != '0) &&
                    (cfg_i.max_per_submit <= SLOT_W'(MAX_POOL)) &&
                    (cfg_i.pool_size != '0) && (cfg_i.pool_size <= SLOT_W'(MAX_POOL)) &&
                    (cfg_i.high_watermark <= cfg_i.pool_size) &&
                    (cfg_i.completion_gap != '0);

  assign do_start  = (mode_q == MODE_START) && start_ok;
  assign do_period = (mode_q == MODE_PERIOD) && running_q;

  // The phase register tracks period_count modulo the completion gap, so the
  // modulo never needs a divider. A saturated period count freezes the phase.
  assign period_sat = (period_q == CNT_MAX);
  assign phase_inc  = phase_q + GAP_W'(1);
  assign phase_new  = period_sat ? phase_q :
                      ((phase_inc == act_q.completion_gap) ? '0 : phase_inc);
  assign cap_hit    = (phase_new == '0);

  assign lead_mid = (cap_hit && lead_q != '0) ? lead_q - SLOT_W'(1) : lead_q;
  assign want     = (act_q.high_watermark > lead_mid) ? act_q.high_watermark - lead_mid : '0;
  assign want_min = (want < act_q.max_per_submit) ? want : act_q.max_per_submit;

  always_comb begin
    if (do_start) begin
      req = {1'b0, cfg_i.target_lead};
    end else if (do_period && fover_q) begin
      req = {1'b0, act_q.max_per_submit} + REQ_W'(1);
    end else if (do_period && !supp_q && lead_mid <= act_q.low_watermark) begin
      req = {1'b0, want_min};
    end else begin
      req = '0;
    end
  end

  // One submit path serves both the initial fill and the watermark refill.
  assign s_max  = do_start ? cfg_i.max_per_submit : act_q.max_per_submit;
  assign s_pool = do_start ? cfg_i.pool_size : act_q.pool_size;
  assign s_lead = do_start ? '0 : lead_mid;
  assign b_ovf  = req > {1'b0, s_max};
  assign s1     = b_ovf ? {1'b0, s_max} : req;
  assign sum    = {1'b0, s_lead} + s1;
  assign p_ovf  = (req != '0) && (sum > {1'b0, s_pool});
  assign room   = (s_pool > s_lead) ? s_pool - s_lead : '0;
  assign grant  = p_ovf ? {1'b0, room} : s1;
  assign go     = (grant != '0);

  assign base_povf  = do_start ? '0 : povf_q;
  assign base_bovf  = do_start ? '0 : bovf_q;
  assign base_total = do_start ? '0 : total_q;
  assign base_calls = do_start ? '0 : calls_q;
  assign base_cbsub = do_start ? '0 : cbsub_q;

  // Safety flags, evaluated on the state left by the step.
  assign f_cad  = (act_q.frames_per_packet == FRAME_W'(ISO_FRAMES)) &&
                  (act_q.completion_gap == GAP_W'(1)) && (cadence_q == '0);
  assign f_cap  = act_q.capture_every_period && (gaps_q == '0);
  assign f_lead = (under_q == '0) && (min_q >= act_q.low_watermark) &&
                  (max_q <= act_q.pool_size);
  assign f_bat  = (act_q.max_per_submit > SLOT_W'(1)) && (calls_q != '0) &&
                  (PROD_W'(total_q) >= prod);
  assign f_pool = (povf_q == '0) && (bovf_q == '0);
  assign f_cb   = (cbsub_q < period_q) && (total_q > calls_q);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    running_d   = running_q;
    lead_d      = lead_q;
    min_d       = min_q;
    max_d       = max_q;
    phase_d     = phase_q;
    period_d    = period_q;
    gaps_d      = gaps_q;
    cadence_d   = cadence_q;
    under_d     = under_q;
    povf_d      = povf_q;
    bovf_d      = bovf_q;
    total_d     = total_q;
    calls_d     = calls_q;
    cbsub_d     = cbsub_q;
    acc_d       = acc_q;
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        acc_d   = 1'b0;
        sub_d   = '0;
        state_d = ST_MUL;
        if (mode_q == MODE_STOP) begin
          running_d = 1'b0;
          lead_d    = '0;
          acc_d     = 1'b1;
        end else if (do_start || do_period) begin
          acc_d = 1'b1;
          if (do_start) begin
            act_d     = cfg_i;
            running_d = 1'b1;
            phase_d   = '0;
            period_d  = '0;
            gaps_d    = '0;
            cadence_d = '0;
            under_d   = '0;
          end else begin
            period_d = sat_inc(period_q);
            phase_d  = phase_new;
            if (!act_q.capture_every_period || fgap_q) begin
              gaps_d = sat_inc(gaps_q);
            end
            if (!cap_hit) begin
              cadence_d = sat_inc(cadence_q);
            end else if (lead_q == '0) begin
              under_d = sat_inc(under_q);
            end
          end
          povf_d  = p_ovf ? sat_inc(base_povf) : base_povf;
          bovf_d  = b_ovf ? sat_inc(base_bovf) : base_bovf;
          total_d = go ? sat_add(base_total, grant) : base_total;
          calls_d = go ? sat_inc(base_calls) : base_calls;
          cbsub_d = (go && do_period) ? sat_inc(base_cbsub) : base_cbsub;
          lead_d  = s_lead + grant[SLOT_W-1:0];
          sub_d   = grant[SLOT_W-1:0];
          if (do_start) begin
            min_d = lead_d;
            max_d = lead_d;
          end else begin
            min_d = (lead_d < min_q) ? lead_d : min_q;
            max_d = (lead_d > max_q) ? lead_d : max_q;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          res_d.accepted        = acc_q;
          res_d.lead_slots      = lead_q;
          res_d.submitted_slots = sub_q;
          res_d.cadence_ok      = running_q & f_cad;
          res_d.capture_ok      = running_q & f_cap;
          res_d.lead_safe       = running_q & f_lead;
          res_d.batching_ok     = running_q & f_bat;
          res_d.pool_ok         = running_q & f_pool;
          res_d.callback_ok     = running_q & f_cb;
          res_d.all_safe        = running_q & f_cad & f_cap & f_lead & f_bat & f_pool & f_cb;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  wrs_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_EXEC),
    .mcand_i  (calls_d),
    .mplier_i (act_d.max_per_submit),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= CFG_RESET;
      running_q   <= 1'b0;
      lead_q      <= '0;
      min_q       <= '0;
      max_q       <= '0;
      phase_q     <= '0;
      period_q    <= '0;
      gaps_q      <= '0;
      cadence_q   <= '0;
      under_q     <= '0;
      povf_q      <= '0;
      bovf_q      <= '0;
      total_q     <= '0;
      calls_q     <= '0;
      cbsub_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      running_q   <= running_d;
      lead_q      <= lead_d;
      min_q       <= min_d;
      max_q       <= max_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      gaps_q      <= gaps_d;
      cadence_q   <= cadence_d;
      under_q     <= under_d;
      povf_q      <= povf_d;
      bovf_q      <= bovf_d;
      total_q     <= total_d;
      calls_q     <= calls_d;
      cbsub_q     <= cbsub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q  <= mode_i;
      fgap_q  <= force_capture_gap_i;
      fover_q <= force_batch_overflow_i;
      supp_q  <= suppress_submit_i;
    end
    acc_q <= acc_d;
    sub_q <= sub_d;
    res_q <= res_d;
  end

endmodule

`default_nettype wire

[design/watermark_refill_scheduler_top.sv]
// Top level of the watermark refill scheduler: register file plus request core.
// Depends on wrs_pkg, wrs_regs and wrs_core (which holds wrs_mul).
//
//   Channel   Direction  Handshake                 Payload
//   request   in         in_valid_i / in_ready_o   mode, force_capture_gap,
//                                                  force_batch_overflow, suppress_submit
//   result    out        out_valid_o / out_ready_i accepted, lead_slots, submitted_slots,
//                                                  seven safety flags
//   config    in/out     psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// Each request is taken in, then updates the lead and all counters, then runs the
// shift-and-add multiplier that forms max_per_submit times submit_calls for the batching
// check, and last loads the result register. Reset is asynchronous and puts every
// counter, the lead and the running flag at zero and the registers at their defaults;
// no clearing pass is needed.
// The result register decouples the two sides, so a new request is taken while a result
// waits; if the next result is ready before the old one is taken, the core holds it.
`default_nettype none

module watermark_refill_scheduler_top import wrs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Request channel.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic              force_capture_gap_i,
  input  wire logic              force_batch_overflow_i,
  input  wire logic              suppress_submit_i,
  // Result channel.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   accepted_o,
  output logic [SLOT_W-1:0]      lead_slots_o,
  output logic [SLOT_W-1:0]      submitted_slots_o,
  output logic                   cadence_ok_o,
  output logic                   capture_ok_o,
  output logic                   lead_safe_o,
  output logic                   batching_ok_o,
  output logic                   pool_ok_o,
  output logic                   callback_ok_o,
  output logic                   all_safe_o,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  result_t res;

  // Live registers; a valid start copies them into the core's active set, so
  // writes made while running only matter at the next start.
  wrs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wrs_core u_core (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .mode_i                 (mode_i),
    .force_capture_gap_i    (force_capture_gap_i),
    .force_batch_overflow_i (force_batch_overflow_i),
    .suppress_submit_i      (suppress_submit_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .res_o                  (res)
  );

  // The result fields come straight from the core's result register.
  assign accepted_o        = res.accepted;
  assign lead_slots_o      = res.lead_slots;
  assign submitted_slots_o = res.submitted_slots;
  assign cadence_ok_o      = res.cadence_ok;
  assign capture_ok_o      = res.capture_ok;
  assign lead_safe_o       = res.lead_safe;
  assign batching_ok_o     = res.batching_ok;
  assign pool_ok_o         = res.pool_ok;
  assign callback_ok_o     = res.callback_ok;
  assign all_safe_o        = res.all_safe;

endmodule

`default_nettype wire

[test/wrs_status_checker.sv]
// Status checker for the watermark refill scheduler testbench.
// Depends on wrs_pkg. Watches the request, result and register ports and predicts each status.
module wrs_status_checker import wrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic              force_capture_gap_i,
  input  logic              force_batch_overflow_i,
  input  logic              suppress_submit_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  result_t           result_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output int                mismatches_o,
  output int                outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned COUNT_CEIL = 64'(CNT_MAX);
  localparam int PRINT_LIMIT = 40;

  // Live registers as written on the bus, and the set latched by the last valid start.
  cfg_t live_regs = CFG_RESET;
  cfg_t active_regs = CFG_RESET;

  bit          started = 1'b0;
  int unsigned lead_now = 0;
  int unsigned lowest_lead = 0;
  int unsigned highest_lead = 0;
  longint unsigned periods, captures, capture_misses, off_cadence, underruns;
  longint unsigned pool_clamps, batch_clamps, slots_total, submits, refill_submits;

  result_t predicted_status[$];
  int      statuses_seen = 0;

  function automatic longint unsigned sat_sum(longint unsigned c, longint unsigned n);
    return (n > COUNT_CEIL - c) ? COUNT_CEIL : c + n;
  endfunction

  function automatic void clear_counters();
    periods = 0; captures = 0; capture_misses = 0; off_cadence = 0; underruns = 0;
    pool_clamps = 0; batch_clamps = 0; slots_total = 0; submits = 0; refill_submits = 0;
  endfunction

  initial clear_counters();

  function automatic bit start_allowed();
    return live_regs.frames_per_packet == ISO_FRAMES && live_regs.target_lead != 0 &&
           live_regs.low_watermark != 0 &&
           live_regs.high_watermark >= live_regs.target_lead &&
           live_regs.low_watermark < live_regs.high_watermark &&
           live_regs.max_per_submit != 0 && live_regs.max_per_submit <= MAX_POOL &&
           live_regs.pool_size != 0 && live_regs.pool_size <= MAX_POOL &&
           live_regs.high_watermark <= live_regs.pool_size &&
           live_regs.completion_gap != 0;
  endfunction

  // One submission: clamp to the per-submit limit, then to what the pool still holds.
  function automatic int unsigned submit_slots(int unsigned ask, bit from_period);
    int unsigned slots;
    slots = ask;
    if (slots == 0) return 0;
    if (slots > active_regs.max_per_submit) begin
      batch_clamps = sat_sum(batch_clamps, 1);
      slots = active_regs.max_per_submit;
    end
    if (lead_now + slots > active_regs.pool_size) begin
      pool_clamps = sat_sum(pool_clamps, 1);
      slots = (active_regs.pool_size > lead_now) ? active_regs.pool_size - lead_now : 0;
    end
    if (slots == 0) return 0;
    lead_now += slots;
    slots_total = sat_sum(slots_total, slots);
    submits = sat_sum(submits, 1);
    if (from_period) refill_submits = sat_sum(refill_submits, 1);
    return slots;
  endfunction

  function automatic result_t step_scheduler(logic [MODE_W-1:0] mode, logic gap_forced,
                                             logic overflow_forced, logic refill_held);
    result_t     r;
    int unsigned sent;
    int unsigned want;
    r = '0;
    sent = 0;
    case (mode)
      MODE_START: begin
        if (start_allowed()) begin
          active_regs = live_regs;
          clear_counters();
          lead_now = 0;
          started = 1'b1;
          sent = submit_slots(active_regs.target_lead, 1'b0);
          lowest_lead = lead_now;
          highest_lead = lead_now;
          r.accepted = 1'b1;
        end
      end
      MODE_STOP: begin
        started = 1'b0;
        lead_now = 0;
        r.accepted = 1'b1;
      end
      MODE_PERIOD: begin
        if (started) begin
          r.accepted = 1'b1;
          periods = sat_sum(periods, 1);
          if (active_regs.capture_every_period && !gap_forced) captures = sat_sum(captures, 1);
          else capture_misses = sat_sum(capture_misses, 1);
          if (active_regs.completion_gap != 0 && periods % active_regs.completion_gap == 0) begin
            if (lead_now == 0) underruns = sat_sum(underruns, 1);
            else lead_now -= 1;
          end else begin
            off_cadence = sat_sum(off_cadence, 1);
          end
          if (overflow_forced) begin
            sent = submit_slots(active_regs.max_per_submit + 1, 1'b1);
          end else if (!refill_held && lead_now <= active_regs.low_watermark) begin
            want = (active_regs.high_watermark > lead_now) ?
                   active_regs.high_watermark - lead_now : 0;
            if (want > active_regs.max_per_submit) want = active_regs.max_per_submit;
            sent = submit_slots(want, 1'b1);
          end
          if (lead_now < lowest_lead) lowest_lead = lead_now;
          if (lead_now > highest_lead) highest_lead = lead_now;
        end
      end
      default: ;
    endcase

    if (started) begin
      r.cadence_ok = active_regs.frames_per_packet == ISO_FRAMES &&
                     active_regs.completion_gap == 1 && off_cadence == 0;
      r.capture_ok = active_regs.capture_every_period && capture_misses == 0;
      r.lead_safe = underruns == 0 && lowest_lead >= active_regs.low_watermark &&
                    highest_lead <= active_regs.pool_size;
      // Average batch of at least max_per_submit, kept in integers.
      r.batching_ok = active_regs.max_per_submit > 1 && submits > 0 &&
                      submits <= slots_total / active_regs.max_per_submit;
      r.pool_ok = pool_clamps == 0 && batch_clamps == 0;
      r.callback_ok = refill_submits < periods && slots_total > submits;
      r.all_safe = r.cadence_ok & r.capture_ok & r.lead_safe & r.batching_ok &
                   r.pool_ok & r.callback_ok;
    end
    r.lead_slots = SLOT_W'(lead_now);
    r.submitted_slots = SLOT_W'(sent);
    return r;
  endfunction

  task automatic note_mismatch(string what);
    mismatches_o++;
    if (mismatches_o <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic compare_field(string name, logic [SLOT_W-1:0] got, logic [SLOT_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("status %0d %s: got %0d, expected %0d",
                              statuses_seen, name, got, want));
  endtask

  task automatic compare_status(result_t got, result_t want);
    compare_field("accepted", got.accepted, want.accepted);
    compare_field("lead_slots", got.lead_slots, want.lead_slots);
    compare_field("submitted_slots", got.submitted_slots, want.submitted_slots);
    compare_field("cadence_ok", got.cadence_ok, want.cadence_ok);
    compare_field("capture_ok", got.capture_ok, want.capture_ok);
    compare_field("lead_safe", got.lead_safe, want.lead_safe);
    compare_field("batching_ok", got.batching_ok, want.batching_ok);
    compare_field("pool_ok", got.pool_ok, want.pool_ok);
    compare_field("callback_ok", got.callback_ok, want.callback_ok);
    compare_field("all_safe", got.all_safe, want.all_safe);
  endtask

  task automatic capture_register_write(logic [REG_IDX_W-1:0] index, logic [APB_DW-1:0] value);
    case (index)
      REG_TARGET:  live_regs.target_lead = value[SLOT_W-1:0];
      REG_LOW:     live_regs.low_watermark = value[SLOT_W-1:0];
      REG_HIGH:    live_regs.high_watermark = value[SLOT_W-1:0];
      REG_MAX:     live_regs.max_per_submit = value[SLOT_W-1:0];
      REG_POOL:    live_regs.pool_size = value[SLOT_W-1:0];
      REG_GAP:     live_regs.completion_gap = value[GAP_W-1:0];
      REG_CAPTURE: live_regs.capture_every_period = value[0];
      REG_FRAMES:  live_regs.frames_per_packet = value[FRAME_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_regs = CFG_RESET;
      active_regs = CFG_RESET;
      started = 1'b0;
      lead_now = 0;
      lowest_lead = 0;
      highest_lead = 0;
      clear_counters();
      predicted_status.delete();
      outstanding_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (predicted_status.size() == 0)
          note_mismatch($sformatf("status %0d arrived with none expected", statuses_seen));
        else
          compare_status(result_i, predicted_status.pop_front());
        statuses_seen++;
      end
      if (req_valid_i && req_ready_i)
        predicted_status.push_back(step_scheduler(mode_i, force_capture_gap_i,
                                                  force_batch_overflow_i, suppress_submit_i));
      if (psel_i && penable_i && pwrite_i && pready_i)
        capture_register_write(paddr_i[APB_AW-1:2], pwdata_i);
      outstanding_o = predicted_status.size();
    end
  end

endmodule

[test/watermark_refill_scheduler_top_test.sv]
// Top of the watermark refill scheduler testbench: clock, reset, request and register stimulus.
// Depends on wrs_pkg, the block watermark_refill_scheduler_top and wrs_status_checker.
module watermark_refill_scheduler_top_test;
  import wrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode value that the block must ignore; the package names only the three real modes.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RESULT_LATENCY = 10;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 148;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PCT       = 24;

  logic clk;
  logic rst_n;

  // Request channel.
  logic              in_valid;
  logic              in_ready;
  logic [MODE_W-1:0] req_mode;
  logic              gap_forced;
  logic              overflow_forced;
  logic              refill_held;

  // Status channel.
  logic              out_valid;
  logic              out_ready;
  logic              accepted;
  logic [SLOT_W-1:0] lead_slots;
  logic [SLOT_W-1:0] submitted_slots;
  logic              cadence_ok, capture_ok, lead_safe, batching_ok;
  logic              pool_ok, callback_ok, all_safe;
  result_t           observed;

  // Register port.
  logic              psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;

  int check_fails;
  int in_flight;

  // Shared pacing controls: steady_flow turns idling off on both sides, and each increment
  // of hold_asks makes the status sink serve one hold-off with out_ready held low.
  bit steady_flow = 1'b0;
  int hold_asks = 0;

  // The packed struct puts accepted in the top bit and all_safe in the bottom one.
  assign observed = {accepted, lead_slots, submitted_slots, cadence_ok, capture_ok,
                     lead_safe, batching_ok, pool_ok, callback_ok, all_safe};

  watermark_refill_scheduler_top u_dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .mode_i                 (req_mode),
    .force_capture_gap_i    (gap_forced),
    .force_batch_overflow_i (overflow_forced),
    .suppress_submit_i      (refill_held),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .accepted_o             (accepted),
    .lead_slots_o           (lead_slots),
    .submitted_slots_o      (submitted_slots),
    .cadence_ok_o           (cadence_ok),
    .capture_ok_o           (capture_ok),
    .lead_safe_o            (lead_safe),
    .batching_ok_o          (batching_ok),
    .pool_ok_o              (pool_ok),
    .callback_ok_o          (callback_ok),
    .all_safe_o             (all_safe),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  wrs_status_checker u_checker (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .req_valid_i            (in_valid),
    .req_ready_i            (in_ready),
    .mode_i                 (req_mode),
    .force_capture_gap_i    (gap_forced),
    .force_batch_overflow_i (overflow_forced),
    .suppress_submit_i      (refill_held),
    .res_valid_i            (out_valid),
    .res_ready_i            (out_ready),
    .result_i               (observed),
    .psel_i                 (psel),
    .penable_i              (penable),
    .pwrite_i               (pwrite),
    .pready_i               (pready),
    .paddr_i                (paddr),
    .pwdata_i               (pwdata),
    .mismatches_o           (check_fails),
    .outstanding_o          (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is far shorter than this even with the long hold-off; reaching it means a hang.
  initial begin
    #4_000_000;
    $display("watermark_refill_scheduler_top regression: fail");
    $finish;
  end

  // Status sink. It changes out_ready only at falling edges, idles about a quarter of the
  // time, and serves each hold-off request by keeping out_ready low for a counted stretch
  // while the stimulus keeps offering requests, so the block fills and stalls its input.
  initial begin : status_sink
    int holds_served;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_asks) begin
        holds_served = hold_asks;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offers one request and returns at the rising edge that accepts it. Valid stays high
  // afterwards; the next call either replaces the payload or drops valid for a gap.
  task automatic offer_request(logic [MODE_W-1:0] mode, logic gap, logic over, logic held);
    int idle_cycles;
    idle_cycles = 0;
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) idle_cycles = $urandom_range(1, 6);
    @(negedge clk);
    if (idle_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (idle_cycles) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_mode <= mode;
    gap_forced <= gap;
    overflow_forced <= over;
    refill_held <= held;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every predicted status has been taken.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  // One register write: a setup phase, then an access phase that completes on pready.
  // psel stays high between back-to-back writes; load_config closes the burst.
  task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [APB_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({index, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_config(cfg_t regs);
    write_reg(REG_TARGET, APB_DW'(regs.target_lead));
    write_reg(REG_LOW, APB_DW'(regs.low_watermark));
    write_reg(REG_HIGH, APB_DW'(regs.high_watermark));
    write_reg(REG_MAX, APB_DW'(regs.max_per_submit));
    write_reg(REG_POOL, APB_DW'(regs.pool_size));
    write_reg(REG_GAP, APB_DW'(regs.completion_gap));
    write_reg(REG_CAPTURE, APB_DW'(regs.capture_every_period));
    write_reg(REG_FRAMES, APB_DW'(regs.frames_per_packet));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A register set that passes the start check. Most sets use a completion every period,
  // since other gaps flag every off-beat period as a cadence violation.
  function automatic cfg_t pick_valid_cfg();
    cfg_t c;
    int   roll;
    c.pool_size = $urandom_range(2, MAX_POOL);
    c.high_watermark = $urandom_range(2, c.pool_size);
    c.target_lead = $urandom_range(1, c.high_watermark);
    c.low_watermark = $urandom_range(1, c.high_watermark - 1);
    if ($urandom_range(3) == 0) c.max_per_submit = $urandom_range(1, MAX_POOL);
    else c.max_per_submit = $urandom_range(1, 8);
    roll = $urandom_range(99);
    if (roll < 70) c.completion_gap = 1;
    else if (roll < 95) c.completion_gap = $urandom_range(2, 4);
    else c.completion_gap = $urandom_range(5, 255);
    c.capture_every_period = $urandom_range(1);
    c.frames_per_packet = ISO_FRAMES;
    return c;
  endfunction

  // A register set that breaks exactly one of the start rules, so a start changes nothing.
  function automatic cfg_t pick_broken_cfg();
    cfg_t c;
    c = pick_valid_cfg();
    case ($urandom_range(10))
      0: c.frames_per_packet = ISO_FRAMES + $urandom_range(1, 255);
      1: c.target_lead = 0;
      2: c.low_watermark = 0;
      3: c.target_lead = c.high_watermark + 1;
      4: c.low_watermark = c.high_watermark + $urandom_range(0, 127 - c.high_watermark);
      5: c.max_per_submit = 0;
      6: c.max_per_submit = $urandom_range(MAX_POOL + 1, 127);
      7: c.pool_size = 0;
      8: c.pool_size = $urandom_range(MAX_POOL + 1, 127);
      9: c.pool_size = c.high_watermark - 1;
      default: c.completion_gap = 0;
    endcase
    return c;
  endfunction

  // Directed part. It starts on the reset register values, then walks the special cases:
  // periods and stops while stopped, the ignored mode, forced gaps and overflows, an
  // invalid start, the widest settings with both clamps, and registers rewritten while
  // running, which must wait for the next start.
  task automatic run_directed();
    cfg_t regs;
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_UNUSED, 1'b1, 1'b1, 1'b1);
    offer_request(MODE_STOP, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_START, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b1);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_PERIOD, 1'b1, 1'b0, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b1, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b1, 1'b1);
    offer_request(MODE_PERIOD, 1'b1, 1'b1, 1'b1);
    offer_request(MODE_STOP, 1'b1, 1'b1, 1'b1);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b0);
    settle();

    // Widest settings with a wrong frame count: the start must be refused.
    regs = '{target_lead: 7'd64, low_watermark: 7'd63, high_watermark: 7'd64,
             max_per_submit: 7'd64, pool_size: 7'd64, completion_gap: 8'd255,
             capture_every_period: 1'b0, frames_per_packet: 8'd7};
    load_config(regs);
    offer_request(MODE_START, 1'b0, 1'b0, 1'b0);
    settle();

    // Same settings, now valid: the start fills the whole pool at once, and a forced
    // overflow then hits the per-submit clamp and the pool clamp together.
    regs.frames_per_packet = ISO_FRAMES;
    load_config(regs);
    offer_request(MODE_START, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b1, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b0);
    settle();

    // Rewritten while running: the next period still runs on the latched settings.
    regs = '{target_lead: 7'd1, low_watermark: 7'd1, high_watermark: 7'd3,
             max_per_submit: 7'd1, pool_size: 7'd3, completion_gap: 8'd1,
             capture_every_period: 1'b1, frames_per_packet: 8'd8};
    load_config(regs);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_START, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b0);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b1);
    offer_request(MODE_PERIOD, 1'b0, 1'b0, 1'b1);
    offer_request(MODE_PERIOD, 1'b0, 1'b1, 1'b0);
    offer_request(MODE_PERIOD, 1'b1, 1'b0, 1'b0);
    offer_request(MODE_STOP, 1'b0, 1'b0, 1'b0);
    settle();
  endtask

  // One random phase: new registers, a start, then mostly periods with a sprinkling of
  // restarts, stops and ignored modes. Flag rates change from phase to phase. Phase one
  // uses the widest settings and phase two the narrowest; phase three runs without idling,
  // phase five holds the status side off, and phase seven pauses midway until it drains.
  task automatic run_random_phase(int phase);
    cfg_t regs;
    int   gap_pct;
    int   over_pct;
    int   held_pct;
    int   pick;
    logic [MODE_W-1:0] mode;
    settle();
    if (phase == 1)
      regs = '{target_lead: 7'd64, low_watermark: 7'd63, high_watermark: 7'd64,
               max_per_submit: 7'd64, pool_size: 7'd64, completion_gap: 8'd1,
               capture_every_period: 1'b1, frames_per_packet: 8'd8};
    else if (phase == 2)
      regs = '{target_lead: 7'd1, low_watermark: 7'd1, high_watermark: 7'd2,
               max_per_submit: 7'd1, pool_size: 7'd2, completion_gap: 8'd1,
               capture_every_period: 1'b0, frames_per_packet: 8'd8};
    else if ($urandom_range(99) < 15)
      regs = pick_broken_cfg();
    else
      regs = pick_valid_cfg();
    load_config(regs);

    steady_flow = (phase == 3);
    gap_pct = $urandom_range(0, 40);
    over_pct = $urandom_range(0, 25);
    held_pct = $urandom_range(0, 50);
    offer_request(MODE_START, $urandom_range(1), $urandom_range(1), $urandom_range(1));
    for (int n = 1; n < PHASE_ITEMS; n++) begin
      if (phase == 5 && n == 8) hold_asks++;
      if (phase == 7 && n == PHASE_ITEMS / 2) settle();
      pick = $urandom_range(99);
      if (pick < 84) mode = MODE_PERIOD;
      else if (pick < 90) mode = MODE_START;
      else if (pick < 95) mode = MODE_STOP;
      else mode = MODE_UNUSED;
      offer_request(mode, $urandom_range(99) < gap_pct, $urandom_range(99) < over_pct,
                    $urandom_range(99) < held_pct);
    end
    steady_flow = 1'b0;
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    req_mode = MODE_START;
    gap_forced = 1'b0;
    overflow_forced = 1'b0;
    refill_held = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) run_random_phase(phase);

    // Drain, then leave room for anything the block should not have produced.
    settle();
    repeat (2 * RESULT_LATENCY) @(negedge clk);
    if (check_fails == 0 && in_flight == 0)
      $display("watermark_refill_scheduler_top regression: pass");
    else
      $display("watermark_refill_scheduler_top regression: fail");
    $finish;
  end

endmodule
